>>> rtl/quaternion_attitude_integrator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the quaternion attitude integrator
// Shared concurrent assertion forms, clocked on clk and quiet during rst.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ATTITUDE_INTEGRATOR_ASSERT_SVH
`define QUATERNION_ATTITUDE_INTEGRATOR_ASSERT_SVH

// same-cycle implication
`define QAI_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QAI_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/qai_pkg.sv
// ----------------------------------------------------------------------------
// qai_pkg
// Types, constants and the quaternion product table of the attitude integrator.
// ----------------------------------------------------------------------------
package qai_pkg;

  localparam int MUL_W     = 33;
  localparam int DIV_LO_W  = 48;
  localparam int DIV_CNT_W = 6;
  localparam int SQ_W      = 64;
  localparam int ROOT_W    = 32;

  localparam logic [DIV_CNT_W-1:0] ACCEL_ITERS = 6'd48;

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_INERTIA_XX = 2'd0;
  localparam logic [1:0] REG_INERTIA_YY = 2'd1;
  localparam logic [1:0] REG_INERTIA_ZZ = 2'd2;
  localparam logic [1:0] REG_TIME_STEP  = 2'd3;

  typedef struct packed {
    logic                 start;
    logic [31:0]          rem_init;  // upper numerator part, must be below den
    logic [DIV_LO_W-1:0]  num;       // lower numerator bits, left aligned
    logic [DIV_CNT_W-1:0] iters;
    logic [31:0]          den;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_LO_W-1:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic            start;
    logic [SQ_W-1:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } sqrt_rsp_t;

  typedef struct packed {
    logic       neg;
    logic [1:0] qi;
    logic [1:0] wi;
  } pq_term_t;

  // q (x) (0,w): three terms per component, component-major
  function automatic pq_term_t pq_term(input logic [3:0] k);
    pq_term_t t;
    case (k)
      4'd0:    t = '{neg: 1'b1, qi: 2'd1, wi: 2'd0};
      4'd1:    t = '{neg: 1'b1, qi: 2'd2, wi: 2'd1};
      4'd2:    t = '{neg: 1'b1, qi: 2'd3, wi: 2'd2};
      4'd3:    t = '{neg: 1'b0, qi: 2'd0, wi: 2'd0};
      4'd4:    t = '{neg: 1'b0, qi: 2'd2, wi: 2'd2};
      4'd5:    t = '{neg: 1'b1, qi: 2'd3, wi: 2'd1};
      4'd6:    t = '{neg: 1'b0, qi: 2'd0, wi: 2'd1};
      4'd7:    t = '{neg: 1'b1, qi: 2'd1, wi: 2'd2};
      4'd8:    t = '{neg: 1'b0, qi: 2'd3, wi: 2'd0};
      4'd9:    t = '{neg: 1'b0, qi: 2'd0, wi: 2'd2};
      4'd10:   t = '{neg: 1'b0, qi: 2'd1, wi: 2'd1};
      4'd11:   t = '{neg: 1'b1, qi: 2'd2, wi: 2'd0};
      default: t = '{neg: 1'b0, qi: 2'd0, wi: 2'd0};
    endcase
    return t;
  endfunction

endpackage

>>> rtl/quaternion_attitude_integrator.sv
// ----------------------------------------------------------------------------
// quaternion_attitude_integrator
// Fixed-point Euler propagation of an attitude quaternion under body torque.
// ----------------------------------------------------------------------------
// One item runs step_count Euler steps (clamped to MAX_STEPS) and returns one
// normalized quaternion per step, the final one flagged by last_step. The
// block takes one item at a time: in_ready is high only while idle, and each
// result waits in place until out_ready. All multiplies, divisions and square
// roots go through one 33x33 multiplier, a one-bit-per-cycle divider and an
// integer square root under a small sequencer. An item first runs the three
// torque/inertia divisions; each step then updates the rate, forms the
// quaternion product and its p*dt increment, then runs a one-bit-per-cycle
// scaling pass whose length depends on the quaternion magnitude, the square
// root pass and the four normalizing divisions; the last two are skipped once
// the quaternion is zero.
// ----------------------------------------------------------------------------
module quaternion_attitude_integrator import qai_pkg::*; #(
  parameter int MAX_STEPS      = 64,
  parameter int QUAT_FRAC_BITS = 30
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] torque_x,
  input  logic signed [31:0] torque_y,
  input  logic signed [31:0] torque_z,
  input  logic signed [31:0] rate_x,
  input  logic signed [31:0] rate_y,
  input  logic signed [31:0] rate_z,
  input  logic signed [31:0] att_w,
  input  logic signed [31:0] att_x,
  input  logic signed [31:0] att_y,
  input  logic signed [31:0] att_z,
  input  logic [6:0]         step_count,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_w,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic               degenerate,
  output logic               last_step
);

  `include "quaternion_attitude_integrator_assert.svh"

  localparam logic [DIV_CNT_W-1:0] NORM_ITERS = DIV_CNT_W'(QUAT_FRAC_BITS + 1);
  localparam logic [6:0]           STEP_LIMIT = 7'(MAX_STEPS);

  localparam logic [4:0] S_IDLE       = 5'd0;
  localparam logic [4:0] S_ACC_GO     = 5'd1;
  localparam logic [4:0] S_ACC_WAIT   = 5'd2;
  localparam logic [4:0] S_RATE_MUL   = 5'd3;
  localparam logic [4:0] S_RATE_ADD   = 5'd4;
  localparam logic [4:0] S_PQ_MUL     = 5'd5;
  localparam logic [4:0] S_PQ_ACC     = 5'd6;
  localparam logic [4:0] S_PDT_MUL    = 5'd7;
  localparam logic [4:0] S_PDT_ACC    = 5'd8;
  localparam logic [4:0] S_NORM_SHIFT = 5'd9;
  localparam logic [4:0] S_SQ_MUL     = 5'd10;
  localparam logic [4:0] S_SQ_ACC     = 5'd11;
  localparam logic [4:0] S_SQRT_GO    = 5'd12;
  localparam logic [4:0] S_SQRT_WAIT  = 5'd13;
  localparam logic [4:0] S_DIV_GO     = 5'd14;
  localparam logic [4:0] S_DIV_WAIT   = 5'd15;
  localparam logic [4:0] S_OUT        = 5'd16;

  // configuration
  logic [31:0] inertia_xx;
  logic [31:0] inertia_yy;
  logic [31:0] inertia_zz;
  logic [15:0] time_step;
  logic        cfg_wr;

  // sequencer
  logic [4:0] state;
  logic [1:0] idx;
  logic [1:0] term;
  logic [3:0] pq_k;
  logic       half;
  logic [6:0] steps_left;
  logic       degen;

  // working data
  logic signed [31:0] torque [3];
  logic signed [31:0] accel [3];
  logic signed [31:0] rate [3];
  logic signed [31:0] att [4];
  logic [51:0]        mag [4];
  logic               neg [4];
  logic signed [49:0] pacc;
  logic [39:0]        dlo;
  logic [61:0]        sumsq;
  logic [31:0]        root;

  // shared units
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [2*MUL_W-1:0] mul_p;
  div_req_t                  div_req;
  div_rsp_t                  div_rsp;
  sqrt_req_t                 sqrt_req;
  sqrt_rsp_t                 sqrt_rsp;

  // datapath helpers
  pq_term_t           pq;
  logic [31:0]        tmag;
  logic [31:0]        den_sel;
  logic signed [31:0] accel_sat;
  logic signed [33:0] rate_sum;
  logic signed [31:0] rate_sat;
  logic signed [49:0] pq_prod;
  logic signed [49:0] pacc_next;
  logic signed [67:0] dsum;
  logic signed [51:0] vnew;
  logic [51:0]        vmag;
  logic               all_zero;
  logic               any_hi;
  logic               any_top;
  logic [6:0]         count_in;

  qai_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  qai_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  qai_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  // --------------------------------------------------------------------------
  // register port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      inertia_xx <= 32'd65536;
      inertia_yy <= 32'd65536;
      inertia_zz <= 32'd65536;
      time_step  <= 16'd655;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_INERTIA_XX: inertia_xx <= pwdata;
        REG_INERTIA_YY: inertia_yy <= pwdata;
        REG_INERTIA_ZZ: inertia_zz <= pwdata;
        REG_TIME_STEP:  time_step  <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_INERTIA_XX: prdata = inertia_xx;
      REG_INERTIA_YY: prdata = inertia_yy;
      REG_INERTIA_ZZ: prdata = inertia_zz;
      REG_TIME_STEP:  prdata = {16'd0, time_step};
      default:        prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // datapath
  // --------------------------------------------------------------------------
  assign pq       = pq_term(pq_k);
  assign count_in = (step_count > STEP_LIMIT) ? STEP_LIMIT : step_count;

  always_comb begin
    tmag = torque[idx][31] ? 32'(-torque[idx]) : 32'(torque[idx]);
    case (idx)
      2'd0:    den_sel = inertia_xx;
      2'd1:    den_sel = inertia_yy;
      default: den_sel = inertia_zz;
    endcase
    if (den_sel == 32'd0) begin
      den_sel = 32'd1;
    end
  end

  // truncated quotient with sign, saturated to 32 bits
  always_comb begin
    if (torque[idx][31]) begin
      if ((div_rsp.quo[47:32] != 16'd0) || (div_rsp.quo[31] && (div_rsp.quo[30:0] != 31'd0))) begin
        accel_sat = 32'sh8000_0000;
      end else begin
        accel_sat = -$signed(div_rsp.quo[31:0]);
      end
    end else if (div_rsp.quo[47:31] != 17'd0) begin
      accel_sat = 32'sh7FFF_FFFF;
    end else begin
      accel_sat = $signed(div_rsp.quo[31:0]);
    end
  end

  // rate += floor(accel*dt / 2^16), saturated
  assign rate_sum = {{2{rate[idx][31]}}, rate[idx]} + mul_p[49:16];
  always_comb begin
    if (rate_sum[33:31] == 3'b000 || rate_sum[33:31] == 3'b111) begin
      rate_sat = rate_sum[31:0];
    end else if (rate_sum[33]) begin
      rate_sat = 32'sh8000_0000;
    end else begin
      rate_sat = 32'sh7FFF_FFFF;
    end
  end

  // floor(q*w / 2^17), summed with its sign into the component
  assign pq_prod   = {mul_p[65], mul_p[65:17]};
  assign pacc_next = pq.neg ? ((term == 2'd0) ? -pq_prod : pacc - pq_prod)
                            : ((term == 2'd0) ?  pq_prod : pacc + pq_prod);

  // p*dt from two partial products: high signed part and low 24 bits
  assign dsum = ($signed({{2{mul_p[65]}}, mul_p}) <<< 24) + $signed({28'd0, dlo});
  assign vnew = {{20{att[idx][31]}}, att[idx]} + dsum[67:16];
  assign vmag = vnew[51] ? 52'(-vnew) : 52'(vnew);

  always_comb begin
    all_zero = 1'b1;
    any_hi   = 1'b0;
    any_top  = 1'b0;
    for (int i = 0; i < 4; i++) begin
      all_zero = all_zero && (mag[i] == 52'd0);
      any_hi   = any_hi || (mag[i][51:30] != 22'd0);
      any_top  = any_top || (mag[i][51:29] != 23'd0);
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_RATE_MUL: begin
        mul_a = {accel[idx][31], accel[idx]};
        mul_b = {17'd0, time_step};
      end
      S_PQ_MUL: begin
        mul_a = {att[pq.qi][31], att[pq.qi]};
        mul_b = {rate[pq.wi][31], rate[pq.wi]};
      end
      S_PDT_MUL: begin
        mul_a = half ? {{8{pacc[48]}}, pacc[48:24]} : {9'd0, pacc[23:0]};
        mul_b = {17'd0, time_step};
      end
      S_SQ_MUL: begin
        mul_a = {3'd0, mag[idx][29:0]};
        mul_b = {3'd0, mag[idx][29:0]};
      end
      default: ;
    endcase
  end

  always_comb begin
    div_req.start    = 1'b0;
    div_req.rem_init = '0;
    div_req.num      = '0;
    div_req.iters    = ACCEL_ITERS;
    div_req.den      = den_sel;
    case (state)
      S_ACC_GO: begin
        div_req.start = 1'b1;
        div_req.num   = {tmag, 16'd0};
      end
      S_DIV_GO: begin
        // (mag << F) / root: quotient fits in F+1 bits
        div_req.start    = 1'b1;
        div_req.rem_init = {3'd0, mag[idx][29:1]};
        div_req.num      = {mag[idx][0], {(DIV_LO_W-1){1'b0}}};
        div_req.iters    = NORM_ITERS;
        div_req.den      = root;
      end
      default: ;
    endcase
  end

  assign sqrt_req.start    = (state == S_SQRT_GO);
  assign sqrt_req.radicand = {2'b00, sumsq};

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      idx        <= 2'd0;
      term       <= 2'd0;
      pq_k       <= 4'd0;
      half       <= 1'b0;
      steps_left <= 7'd0;
      degen      <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            torque[0]  <= torque_x;
            torque[1]  <= torque_y;
            torque[2]  <= torque_z;
            rate[0]    <= rate_x;
            rate[1]    <= rate_y;
            rate[2]    <= rate_z;
            att[0]     <= att_w;
            att[1]     <= att_x;
            att[2]     <= att_y;
            att[3]     <= att_z;
            steps_left <= count_in;
            idx        <= 2'd0;
            if (count_in != 7'd0) begin
              state <= S_ACC_GO;
            end
          end
        end
        S_ACC_GO: state <= S_ACC_WAIT;
        S_ACC_WAIT: begin
          if (div_rsp.done) begin
            accel[idx] <= accel_sat;
            if (idx == 2'd2) begin
              idx   <= 2'd0;
              state <= S_RATE_MUL;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_ACC_GO;
            end
          end
        end
        S_RATE_MUL: state <= S_RATE_ADD;
        S_RATE_ADD: begin
          rate[idx] <= rate_sat;
          if (idx == 2'd2) begin
            idx   <= 2'd0;
            pq_k  <= 4'd0;
            term  <= 2'd0;
            state <= S_PQ_MUL;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_RATE_MUL;
          end
        end
        S_PQ_MUL: state <= S_PQ_ACC;
        S_PQ_ACC: begin
          pacc <= pacc_next;
          pq_k <= pq_k + 1'b1;
          if (term == 2'd2) begin
            term  <= 2'd0;
            half  <= 1'b0;
            state <= S_PDT_MUL;
          end else begin
            term  <= term + 1'b1;
            state <= S_PQ_MUL;
          end
        end
        S_PDT_MUL: state <= S_PDT_ACC;
        S_PDT_ACC: begin
          if (!half) begin
            dlo   <= mul_p[39:0];
            half  <= 1'b1;
            state <= S_PDT_MUL;
          end else begin
            mag[idx] <= vmag;
            neg[idx] <= vnew[51];
            if (idx == 2'd3) begin
              state <= S_NORM_SHIFT;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_PQ_MUL;
            end
          end
        end
        S_NORM_SHIFT: begin
          // bring the largest magnitude into [2^29, 2^30), one bit a cycle, or flag all zero
          if (all_zero) begin
            for (int i = 0; i < 4; i++) begin
              att[i] <= 32'sd0;
            end
            degen <= 1'b1;
            state <= S_OUT;
          end else if (any_hi) begin
            for (int i = 0; i < 4; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else if (!any_top) begin
            for (int i = 0; i < 4; i++) begin
              mag[i] <= mag[i] << 1;
            end
          end else begin
            idx   <= 2'd0;
            sumsq <= '0;
            state <= S_SQ_MUL;
          end
        end
        S_SQ_MUL: state <= S_SQ_ACC;
        S_SQ_ACC: begin
          sumsq <= sumsq + {2'b00, mul_p[59:0]};
          if (idx == 2'd3) begin
            state <= S_SQRT_GO;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_SQ_MUL;
          end
        end
        S_SQRT_GO: state <= S_SQRT_WAIT;
        S_SQRT_WAIT: begin
          if (sqrt_rsp.done) begin
            root  <= sqrt_rsp.root;
            idx   <= 2'd0;
            state <= S_DIV_GO;
          end
        end
        S_DIV_GO: state <= S_DIV_WAIT;
        S_DIV_WAIT: begin
          if (div_rsp.done) begin
            att[idx] <= neg[idx] ? -$signed(div_rsp.quo[31:0]) : $signed(div_rsp.quo[31:0]);
            if (idx == 2'd3) begin
              degen <= 1'b0;
              state <= S_OUT;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_DIV_GO;
            end
          end
        end
        S_OUT: begin
          if (out_ready) begin
            steps_left <= steps_left - 1'b1;
            idx        <= 2'd0;
            state      <= (steps_left == 7'd1) ? S_IDLE : S_RATE_MUL;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign out_valid  = (state == S_OUT);
  assign out_w      = att[0];
  assign out_x      = att[1];
  assign out_y      = att[2];
  assign out_z      = att[3];
  assign degenerate = degen;
  assign last_step  = (steps_left == 7'd1);

  `QAI_ASSERT_IMP(a_one_side, out_valid, !in_ready, "item taken while a result is pending")
  `QAI_ASSERT_IMP(a_degen_zero, out_valid && degenerate, out_w == 32'sd0 && out_x == 32'sd0 && out_y == 32'sd0 && out_z == 32'sd0, "degenerate result not zero")
  `QAI_ASSERT_NXT(a_run_continues, out_valid && out_ready && !last_step, !in_ready, "run ended early")
  `QAI_ASSERT_NXT(a_run_ends, out_valid && out_ready && last_step, in_ready, "run did not end on last step")

endmodule

>>> rtl/qai_mul.sv
// ----------------------------------------------------------------------------
// qai_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module qai_mul import qai_pkg::*; (
  input  logic                      clk,
  input  logic signed [MUL_W-1:0]   a,
  input  logic signed [MUL_W-1:0]   b,
  output logic signed [2*MUL_W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

>>> rtl/qai_div.sv
// ----------------------------------------------------------------------------
// qai_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module qai_div import qai_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [DIV_CNT_W-1:0] cnt;
  logic [31:0]          rem;
  logic [DIV_LO_W-1:0]  lo;
  logic [31:0]          den;
  logic [32:0]          sh;
  logic                 ge;

  assign sh = {rem, lo[DIV_LO_W-1]};
  assign ge = sh >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        rem  <= req.rem_init;
        lo   <= req.num;
        den  <= req.den;
        cnt  <= req.iters;
      end else if (busy) begin
        rem <= ge ? 32'(sh - {1'b0, den}) : sh[31:0];
        lo  <= {lo[DIV_LO_W-2:0], ge};
        cnt <= cnt - 1'b1;
        if (cnt == DIV_CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quo  = lo;

endmodule

>>> rtl/qai_sqrt.sv
// ----------------------------------------------------------------------------
// qai_sqrt
// Integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module qai_sqrt import qai_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  logic            busy;
  logic            done;
  logic [SQ_W-1:0] n;
  logic [SQ_W-1:0] res;
  logic [SQ_W-1:0] bitr;
  logic [SQ_W-1:0] trial;

  assign trial = res + bitr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        n    <= req.radicand;
        res  <= '0;
        bitr <= {2'b01, {(SQ_W-2){1'b0}}};
      end else if (busy) begin
        if (n >= trial) begin
          n   <= n - trial;
          res <= (res >> 1) + bitr;
        end else begin
          res <= res >> 1;
        end
        bitr <= bitr >> 2;
        if (bitr[0]) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = res[ROOT_W-1:0];

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Attitude integrator testbench
// Drives torque/rate/attitude items through the valid/ready input, runs the
// Euler propagation in a bit-exact software predictor, and checks every
// emitted quaternion step in order. Inertia and time step are written over APB
// between phases, extremes included. Both sides idle at random, bar one phase.
// ----------------------------------------------------------------------------
module testbench;
  import qai_pkg::*;

  typedef struct packed {
    logic [31:0] torque_x, torque_y, torque_z;
    logic [31:0] rate_x, rate_y, rate_z;
    logic [31:0] att_w, att_x, att_y, att_z;
    logic [6:0]  steps;
  } item_t;

  typedef struct packed {
    logic [31:0] w, x, y, z;
    logic        degen;
    logic        last;
  } quat_out_t;

  localparam int  STEP_LIMIT  = 64;
  localparam int  FRAC        = 30;
  localparam longint CYCLE_LIMIT = 12000000;

  logic clk, rst;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] torque_x, torque_y, torque_z, rate_x, rate_y, rate_z;
  logic signed [31:0] att_w, att_x, att_y, att_z;
  logic [6:0] step_count;
  logic signed [31:0] out_w, out_x, out_y, out_z;
  logic degenerate, last_step;

  quaternion_attitude_integrator dut (.*);

  // shadow of the configuration registers
  longint inertia_cfg[3];
  longint dt_cfg;

  item_t     pending_items[$];
  quat_out_t expected_quats[$];
  int        mismatches = 0;
  int        items_sent = 0, steps_seen = 0, degen_seen = 0;
  bit        quiet = 0;
  longint    cycles = 0;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_quats.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic longint sat32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned res = 0, b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // scale to [2^29, 2^30), divide by the root; returns 1 for an all-zero quaternion
  task automatic renormalize(inout longint q[4], output bit zero);
    longint unsigned mag[4];
    longint unsigned m = 0, sum = 0, root, quo;
    bit neg[4];
    int s = 0;
    for (int i = 0; i < 4; i++) begin
      neg[i] = q[i] < 0;
      mag[i] = neg[i] ? -q[i] : q[i];
      if (mag[i] > m) m = mag[i];
    end
    zero = (m == 0);
    if (zero) begin
      for (int i = 0; i < 4; i++) q[i] = 0;
      return;
    end
    if (m >= (64'd1 << 30)) begin
      while ((m >> s) >= (64'd1 << 30)) s++;
      for (int i = 0; i < 4; i++) mag[i] = mag[i] >> s;
    end else begin
      while ((m << s) < (64'd1 << 29)) s++;
      for (int i = 0; i < 4; i++) mag[i] = mag[i] << s;
    end
    for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
    root = int_sqrt(sum);
    for (int i = 0; i < 4; i++) begin
      quo = (mag[i] << FRAC) / root;
      q[i] = neg[i] ? -longint'(quo) : longint'(quo);
    end
  endtask

  task automatic propagate_attitude(input item_t it);
    longint tq[3], acc[3], w[3], q[4], p[4], dv;
    int n;
    bit zero;
    quat_out_t r;
    tq[0] = $signed(it.torque_x); tq[1] = $signed(it.torque_y);
    tq[2] = $signed(it.torque_z);
    w[0] = $signed(it.rate_x); w[1] = $signed(it.rate_y); w[2] = $signed(it.rate_z);
    q[0] = $signed(it.att_w); q[1] = $signed(it.att_x);
    q[2] = $signed(it.att_y); q[3] = $signed(it.att_z);
    for (int i = 0; i < 3; i++) begin
      dv = inertia_cfg[i];
      if (dv == 0) dv = 1;
      acc[i] = sat32((tq[i] * 65536) / dv);
    end
    n = it.steps;
    if (n > STEP_LIMIT) n = STEP_LIMIT;
    for (int k = n - 1; k >= 0; k--) begin
      for (int i = 0; i < 3; i++) w[i] = sat32(w[i] + ((acc[i] * dt_cfg) >>> 16));
      p[0] = -((q[1] * w[0]) >>> 17) - ((q[2] * w[1]) >>> 17) - ((q[3] * w[2]) >>> 17);
      p[1] = ((q[0] * w[0]) >>> 17) + ((q[2] * w[2]) >>> 17) - ((q[3] * w[1]) >>> 17);
      p[2] = ((q[0] * w[1]) >>> 17) - ((q[1] * w[2]) >>> 17) + ((q[3] * w[0]) >>> 17);
      p[3] = ((q[0] * w[2]) >>> 17) + ((q[1] * w[1]) >>> 17) - ((q[2] * w[0]) >>> 17);
      for (int i = 0; i < 4; i++) q[i] = q[i] + ((p[i] * dt_cfg) >>> 16);
      renormalize(q, zero);
      r.w = q[0][31:0]; r.x = q[1][31:0]; r.y = q[2][31:0]; r.z = q[3][31:0];
      r.degen = zero;
      r.last = (k == 0);
      expected_quats.insert(expected_quats.size(), r);
    end
  endtask

  // input side: one item in flight, random gap before each new one
  item_t cur_item;
  int    send_gap;
  bit    holding;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      holding = in_valid;
      if (in_valid && in_ready) begin
        propagate_attitude(cur_item);
        items_sent++;
        holding = 0;
      end
      if (!holding) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          torque_x <= cur_item.torque_x; torque_y <= cur_item.torque_y;
          torque_z <= cur_item.torque_z;
          rate_x <= cur_item.rate_x; rate_y <= cur_item.rate_y;
          rate_z <= cur_item.rate_z;
          att_w <= cur_item.att_w; att_x <= cur_item.att_x;
          att_y <= cur_item.att_y; att_z <= cur_item.att_z;
          step_count <= cur_item.steps;
          in_valid <= 1'b1;
          send_gap = quiet ? 0 : $urandom_range(0, 16);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output side: check each accepted step, random stall before the next
  int        recv_stall;
  quat_out_t want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        steps_seen++;
        if (degenerate) degen_seen++;
        if (expected_quats.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result w=%h x=%h y=%h z=%h", out_w, out_x, out_y, out_z);
        end else begin
          want = expected_quats.pop_front();
          if (out_w !== want.w || out_x !== want.x || out_y !== want.y ||
              out_z !== want.z || degenerate !== want.degen || last_step !== want.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %h %h %h %h dg=%b last=%b, got %h %h %h %h dg=%b last=%b",
                       want.w, want.x, want.y, want.z, want.degen, want.last,
                       out_w, out_x, out_y, out_z, degenerate, last_step);
          end
        end
        recv_stall = quiet ? 0 : $urandom_range(0, 16);
      end else if (recv_stall > 0) begin
        recv_stall--;
      end
      out_ready <= (recv_stall == 0);
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_INERTIA_XX: inertia_cfg[0] = val;
      REG_INERTIA_YY: inertia_cfg[1] = val;
      REG_INERTIA_ZZ: inertia_cfg[2] = val;
      REG_TIME_STEP:  dt_cfg = val[15:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [31:0] ixx, iyy, izz, input logic [15:0] dt);
    reg_write(REG_INERTIA_XX, ixx);
    reg_write(REG_INERTIA_YY, iyy);
    reg_write(REG_INERTIA_ZZ, izz);
    // upper bits of time_step are junk and must be ignored
    reg_write(REG_TIME_STEP, {16'($urandom), dt});
  endtask

  // all outstanding results in, then room for a zero-step item still in flight
  task automatic drain;
    while (pending_items.size() > 0 || in_valid || expected_quats.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [31:0] near(input int lim);
    return 32'($urandom_range(0, 2 * lim)) - 32'(lim);
  endfunction

  function automatic item_t rand_item;
    item_t it;
    int pick = $urandom_range(0, 9);
    if (pick < 7) begin
      // plausible attitude, modest rates and torques
      it = '{torque_x: near(1 << 20), torque_y: near(1 << 20), torque_z: near(1 << 20),
             rate_x: near(1 << 19), rate_y: near(1 << 19), rate_z: near(1 << 19),
             att_w: near(1 << 30), att_x: near(1 << 30), att_y: near(1 << 30),
             att_z: near(1 << 30), steps: 7'($urandom_range(1, 8))};
    end else begin
      it = '{torque_x: $urandom, torque_y: $urandom, torque_z: $urandom,
             rate_x: $urandom, rate_y: $urandom, rate_z: $urandom,
             att_w: $urandom, att_x: $urandom, att_y: $urandom, att_z: $urandom,
             steps: 7'($urandom_range(0, 6))};
      if (pick == 9) begin
        it.att_w = 0; it.att_x = 0; it.att_y = 0; it.att_z = near(1);
      end
    end
    if ($urandom_range(0, 14) == 0) it.steps = 7'($urandom_range(60, 127));
    return it;
  endfunction

  localparam logic [31:0] MAXP = 32'h7fffffff;
  localparam logic [31:0] MINN = 32'h80000000;
  localparam logic [31:0] ONE_Q = 32'h40000000;

  task automatic enqueue_item(input item_t it);
    pending_items.insert(pending_items.size(), it);
  endtask

  task automatic random_phase(input int n);
    for (int i = 0; i < n; i++) enqueue_item(rand_item());
  endtask

  initial begin
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    in_valid = 0; out_ready = 0;
    torque_x = 0; torque_y = 0; torque_z = 0; rate_x = 0; rate_y = 0; rate_z = 0;
    att_w = 0; att_x = 0; att_y = 0; att_z = 0; step_count = 0;
    inertia_cfg[0] = 65536; inertia_cfg[1] = 65536; inertia_cfg[2] = 65536;
    dt_cfg = 655;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed, reset configuration
    enqueue_item('{0, 0, 0, 0, 0, 0, ONE_Q, 0, 0, 0, 7'd3});
    enqueue_item('{0, 0, 0, 32'h10000, 0, 0, 0, 0, 0, 0, 7'd4}); // zero quaternion
    enqueue_item('{MAXP, MINN, MAXP, MAXP, MINN, 0, ONE_Q, 0, 0, 0, 7'd5});
    enqueue_item('{MINN, MAXP, MINN, MINN, MAXP, MAXP, 0, ONE_Q, 0, 0, 7'd2});
    enqueue_item('{0, 0, 0, 0, 0, 0, MAXP, MAXP, MAXP, MAXP, 7'd2});
    enqueue_item('{0, 0, 0, 0, 0, 0, MINN, MINN, MINN, MINN, 7'd2});
    enqueue_item('{0, 0, 0, 0, 0, 0, 32'h1, 0, 0, 32'hffffffff, 7'd2});
    enqueue_item('{1, 2, 3, 4, 5, 6, ONE_Q, 0, 0, 0, 7'd0});  // no results
    enqueue_item('{0, 0, 32'h20000, 0, 0, 32'h8000, 0, 0, ONE_Q, 0, 7'd64});
    enqueue_item('{32'h30000, 0, 0, 32'h4000, 0, 0, 0, 0, 0, ONE_Q, 7'd127});
    enqueue_item('{0, 32'hffff0000, 0, 0, 32'h1000, 0, ONE_Q, 0, 0, 0, 7'd65});
    random_phase(6);
    drain();

    // minimum inertia, longest step: saturation of rate and accel
    configure(32'd1, 32'd1, 32'd1, 16'hffff);
    enqueue_item('{MAXP, MINN, 32'h1, MAXP, MINN, 0, ONE_Q, 0, 0, 0, 7'd6});
    random_phase(16);
    drain();

    // zero inertia and zero time step
    configure(32'd0, 32'd0, 32'd0, 16'd0);
    enqueue_item('{MAXP, MAXP, MAXP, 32'h10000, 0, 0, 32'h12345, 0, 0, 0, 7'd3});
    random_phase(14);
    drain();

    // maximum inertia, smallest nonzero time step, no idling on either side
    quiet = 1;
    configure(32'hffffffff, 32'hffffffff, 32'hffffffff, 16'd1);
    random_phase(16);
    drain();
    quiet = 0;

    configure($urandom, $urandom, $urandom, 16'($urandom));
    random_phase(16);
    drain();

    configure(32'h8000, 32'h30000, 32'h10000, 16'd4096);
    random_phase(16);
    drain();

    $display("%0d items sent, %0d steps checked (%0d degenerate) over six register settings",
             items_sent, steps_seen, degen_seen);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/qai_pkg.sv
rtl/qai_mul.sv
rtl/qai_div.sv
rtl/qai_sqrt.sv
rtl/quaternion_attitude_integrator.sv
tb/sv/testbench.sv
